>>> src/gcie_pkg.sv
// ----------------------------------------------------------------------------
// gcie_pkg
// Shared constants, types and helpers of the grid cell ink extent block.
// ----------------------------------------------------------------------------
package gcie_pkg;

   localparam int GRID_CELLS      = 10;
   localparam int MAX_CELL_WIDTH  = 256;
   localparam int MAX_IMAGE_WIDTH = 4096;

   localparam int COL_W  = $clog2(MAX_IMAGE_WIDTH);
   localparam int IW_W   = COL_W + 1;
   localparam int X_W    = $clog2(MAX_CELL_WIDTH);
   localparam int CW_W   = X_W + 1;
   localparam int CELL_W = $clog2(GRID_CELLS + 1);
   localparam int CIX_W  = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int IDX_W  = $clog2(GRID_CELLS * GRID_CELLS + 1);
   localparam int DCNT_W = $clog2(COL_W + 1);

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam int PIXEL_W  = 8;
   localparam int IMGW_W   = 13;
   localparam int CSIZE_W  = 9;
   localparam int THR_W    = 8;
   localparam int GLYPH_W  = 7;
   localparam int CIDX_W   = 7;
   localparam int COLOUT_W = 9;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [IMGW_W-1:0]  IMAGE_WIDTH_RST   = IMGW_W'(640);
   localparam logic [CSIZE_W-1:0] CELL_WIDTH_RST    = CSIZE_W'(64);
   localparam logic [CSIZE_W-1:0] CELL_HEIGHT_RST   = CSIZE_W'(64);
   localparam logic [THR_W-1:0]   INK_THRESHOLD_RST = THR_W'(60);
   localparam logic [GLYPH_W-1:0] GLYPH_COUNT_RST   = GLYPH_W'(95);

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_CELL_WIDTH    = 3'd1,
      REG_CELL_HEIGHT   = 3'd2,
      REG_INK_THRESHOLD = 3'd3,
      REG_GLYPH_COUNT   = 3'd4
   } csr_index_type;

   typedef enum logic {
      BK_RUN,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [IMGW_W-1:0]  image_width;
      logic [CSIZE_W-1:0] cell_width;
      logic [CSIZE_W-1:0] cell_height;
      logic [THR_W-1:0]   ink_threshold;
      logic [GLYPH_W-1:0] glyph_count;
   } cfg_type;

   typedef struct packed {
      logic              clear;
      logic              ink;
      logic [CELL_W-1:0] cell_pos;
      logic [X_W-1:0]    x;
      logic              flush;
      logic [CELL_W-1:0] row;
   } pix_item_type;

   function automatic int clamp_size(input int v, input int hi);
      int r;
      r = v;
      if (v == 0) r = 1;
      else if (v > hi) r = hi;
      return r;
   endfunction

endpackage

>>> src/grid_cell_ink_extent_top.sv
// ----------------------------------------------------------------------------
// grid_cell_ink_extent_top
// Horizontal ink extent of every cell of a fixed grid over a raster image.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the queue has room and the divider is idle.
// At the end of each cell row the result sequencer reads the per-cell extent
// registers and reports up to GRID_CELLS cells as the response side accepts
// them; a four-entry pixel queue absorbs this so intake goes on until it fills.
// A write to cell_width holds off requests while a serial divider re-derives
// the cell position of the current column.
module grid_cell_ink_extent_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gcie_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gcie_pkg::CIDX_W-1:0]     rsp_cell_index,
   output logic [gcie_pkg::COLOUT_W-1:0]   rsp_first_column,
   output logic [gcie_pkg::COLOUT_W-1:0]   rsp_end_column,
   output logic                            rsp_empty_cell,
   output logic                            rsp_last_of_run,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gcie_pkg::CSR_AW-1:0]     paddr,
   input  logic [gcie_pkg::CSR_DW-1:0]     pwdata,
   output logic [gcie_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready
);
   import gcie_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type widx;
   logic          wr_en, cw_wr;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   pix_item_type  push_item, pop_item;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign widx   = csr_index_type'(paddr[4:2]);
   assign cw_wr  = wr_en && (widx == REG_CELL_WIDTH);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (widx)
            REG_IMAGE_WIDTH:   cfg_in.image_width   = pwdata[IMGW_W-1:0];
            REG_CELL_WIDTH:    cfg_in.cell_width    = pwdata[CSIZE_W-1:0];
            REG_CELL_HEIGHT:   cfg_in.cell_height   = pwdata[CSIZE_W-1:0];
            REG_INK_THRESHOLD: cfg_in.ink_threshold = pwdata[THR_W-1:0];
            REG_GLYPH_COUNT:   cfg_in.glyph_count   = pwdata[GLYPH_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(paddr[4:2]))
         REG_IMAGE_WIDTH:   prdata = CSR_DW'(cfg_ff.image_width);
         REG_CELL_WIDTH:    prdata = CSR_DW'(cfg_ff.cell_width);
         REG_CELL_HEIGHT:   prdata = CSR_DW'(cfg_ff.cell_height);
         REG_INK_THRESHOLD: prdata = CSR_DW'(cfg_ff.ink_threshold);
         REG_GLYPH_COUNT:   prdata = CSR_DW'(cfg_ff.glyph_count);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= IMAGE_WIDTH_RST;
         cfg_ff.cell_width    <= CELL_WIDTH_RST;
         cfg_ff.cell_height   <= CELL_HEIGHT_RST;
         cfg_ff.ink_threshold <= INK_THRESHOLD_RST;
         cfg_ff.glyph_count   <= GLYPH_COUNT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcie_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .cw_wr           (cw_wr),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_start (req_frame_start),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_item       (push_item)
   );

   gcie_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   gcie_back u_back (
      .clock            (clock),
      .reset            (reset),
      .glyph_count      (cfg_ff.glyph_count),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cell_index   (rsp_cell_index),
      .rsp_first_column (rsp_first_column),
      .rsp_end_column   (rsp_end_column),
      .rsp_empty_cell   (rsp_empty_cell),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> src/gcie_front.sv
// ----------------------------------------------------------------------------
// gcie_front
// Pixel intake: raster counters, cell classification, ink test, and a
// serial divider that re-derives the cell position after a cell width write.
// ----------------------------------------------------------------------------
module gcie_front (
   input  logic                            clock,
   input  logic                            reset,
   input  gcie_pkg::cfg_type               cfg,
   input  logic                            cw_wr,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gcie_pkg::PIXEL_W-1:0]    req_pixel,
   input  logic                            req_frame_start,
   output logic                            push_valid,
   input  logic                            push_ready,
   output gcie_pkg::pix_item_type          push_item
);
   import gcie_pkg::*;

   logic [COL_W-1:0]  col_ff, col_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [CELL_W-1:0] c_ff, c_in;
   logic [X_W-1:0]    row_ff, row_in;
   logic [CELL_W-1:0] crow_ff, crow_in;

   logic              busy_ff, busy_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [CW_W-1:0]   drem_ff, drem_in;
   logic [COL_W-1:0]  dq_ff, dq_in;
   logic [COL_W-1:0]  dsh_ff, dsh_in;

   logic [CW_W-1:0]   cw_eff, ch_eff;
   logic [IW_W-1:0]   iw_eff;
   logic [COL_W-1:0]  col_e;
   logic [X_W-1:0]    x_e, row_e;
   logic [CELL_W-1:0] c_e, crow_e;
   logic              accept, in_grid, in_cells, line_end, row_end;
   logic [CW_W:0]     trial;
   logic [CW_W-1:0]   rem_next;
   logic [COL_W-1:0]  q_next;

   assign cw_eff = CW_W'(clamp_size(int'(cfg.cell_width), MAX_CELL_WIDTH));
   assign ch_eff = CW_W'(clamp_size(int'(cfg.cell_height), MAX_CELL_WIDTH));
   assign iw_eff = IW_W'(clamp_size(int'(cfg.image_width), MAX_IMAGE_WIDTH));

   assign req_ready = !busy_ff && push_ready;
   assign accept    = req_valid && req_ready;

   assign col_e  = req_frame_start ? '0 : col_ff;
   assign x_e    = req_frame_start ? '0 : x_ff;
   assign c_e    = req_frame_start ? '0 : c_ff;
   assign row_e  = req_frame_start ? '0 : row_ff;
   assign crow_e = req_frame_start ? '0 : crow_ff;

   assign in_grid  = int'(crow_e) < GRID_CELLS;
   assign in_cells = int'(c_e) < GRID_CELLS;
   assign line_end = !(({1'b0, col_e} + IW_W'(1)) < iw_eff);
   assign row_end  = line_end && !(({1'b0, row_e} + CW_W'(1)) < ch_eff);

   assign push_valid         = accept && in_grid;
   assign push_item.clear    = req_frame_start;
   assign push_item.ink      = in_cells && (req_pixel > cfg.ink_threshold);
   assign push_item.cell_pos = c_e;
   assign push_item.x        = x_e;
   assign push_item.flush    = row_end;
   assign push_item.row      = crow_e;

   // restoring division step: column position by cell width
   assign trial    = {drem_ff, dsh_ff[COL_W-1]};
   assign rem_next = (trial >= {1'b0, cw_eff}) ? CW_W'(trial - {1'b0, cw_eff})
                                               : trial[CW_W-1:0];
   assign q_next   = {dq_ff[COL_W-2:0], trial >= {1'b0, cw_eff}};

   always_comb begin
      col_in  = col_ff;
      x_in    = x_ff;
      c_in    = c_ff;
      row_in  = row_ff;
      crow_in = crow_ff;
      busy_in = busy_ff;
      dcnt_in = dcnt_ff;
      drem_in = drem_ff;
      dq_in   = dq_ff;
      dsh_in  = dsh_ff;
      if (cw_wr) begin
         busy_in = 1'b1;
         dcnt_in = '0;
         drem_in = '0;
         dq_in   = '0;
         dsh_in  = col_ff;
      end else if (busy_ff) begin
         drem_in = rem_next;
         dq_in   = q_next;
         dsh_in  = {dsh_ff[COL_W-2:0], 1'b0};
         dcnt_in = dcnt_ff + DCNT_W'(1);
         if (int'(dcnt_ff) == COL_W - 1) begin
            busy_in = 1'b0;
            x_in    = rem_next[X_W-1:0];
            c_in    = (int'(q_next) >= GRID_CELLS) ? CELL_W'(GRID_CELLS)
                                                   : q_next[CELL_W-1:0];
         end
      end else if (accept && in_grid) begin
         if (!line_end) begin
            col_in = col_e + COL_W'(1);
            x_in   = x_e;
            c_in   = c_e;
            row_in = row_e;
            crow_in = crow_e;
            if (in_cells) begin
               if (({1'b0, x_e} + CW_W'(1)) >= cw_eff) begin
                  x_in = '0;
                  c_in = c_e + CELL_W'(1);
               end else begin
                  x_in = x_e + X_W'(1);
               end
            end
         end else begin
            col_in = '0;
            x_in   = '0;
            c_in   = '0;
            if (!row_end) begin
               row_in  = row_e + X_W'(1);
               crow_in = crow_e;
            end else begin
               row_in  = '0;
               crow_in = crow_e + CELL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         x_ff    <= '0;
         c_ff    <= '0;
         row_ff  <= '0;
         crow_ff <= '0;
         busy_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         col_ff  <= col_in;
         x_ff    <= x_in;
         c_ff    <= c_in;
         row_ff  <= row_in;
         crow_ff <= crow_in;
         busy_ff <= busy_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      drem_ff <= drem_in;
      dq_ff   <= dq_in;
      dsh_ff  <= dsh_in;
   end

   a_cw_write_holds_intake: assert property (@(posedge clock) disable iff (reset)
      cw_wr |=> !req_ready)
      else $error("request taken while cell position is re-derived");

endmodule

>>> src/gcie_fifo.sv
// ----------------------------------------------------------------------------
// gcie_fifo
// Short queue of classified pixels between intake and extent update.
// ----------------------------------------------------------------------------
module gcie_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  gcie_pkg::pix_item_type push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output gcie_pkg::pix_item_type pop_item
);
   import gcie_pkg::*;

   pix_item_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ff, wr_in;
   logic [FIFO_AW-1:0] rd_ff, rd_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               push, pop;

   assign push_ready = int'(cnt_ff) < FIFO_DEPTH;
   assign pop_valid  = cnt_ff != '0;
   assign pop_item   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_in  = push ? ((int'(wr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ff + FIFO_AW'(1)) : wr_ff;
      rd_in  = pop  ? ((int'(rd_ff) == FIFO_DEPTH - 1) ? '0 : rd_ff + FIFO_AW'(1)) : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("queue written while full");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + (FIFO_AW + 1)'(1))
      else $error("queue fill count lost a write");

endmodule

>>> src/gcie_back.sv
// ----------------------------------------------------------------------------
// gcie_back
// Per-cell ink extent registers and result sequencing at each cell row end.
// ----------------------------------------------------------------------------
module gcie_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [gcie_pkg::GLYPH_W-1:0]    glyph_count,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  gcie_pkg::pix_item_type          pop_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gcie_pkg::CIDX_W-1:0]     rsp_cell_index,
   output logic [gcie_pkg::COLOUT_W-1:0]   rsp_first_column,
   output logic [gcie_pkg::COLOUT_W-1:0]   rsp_end_column,
   output logic                            rsp_empty_cell,
   output logic                            rsp_last_of_run
);
   import gcie_pkg::*;

   back_state_type      state_ff, state_in;
   logic [X_W-1:0]      first_ff [GRID_CELLS];
   logic [X_W-1:0]      first_in [GRID_CELLS];
   logic [X_W-1:0]      last_ff  [GRID_CELLS];
   logic [X_W-1:0]      last_in  [GRID_CELLS];
   logic [GRID_CELLS-1:0] seen_ff, seen_in;
   logic [CIX_W-1:0]    emit_ff, emit_in;
   logic [CELL_W-1:0]   row_ff, row_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CIDX_W-1:0]   cidx_ff, cidx_in;
   logic [COLOUT_W-1:0] first_col_ff, first_col_in;
   logic [COLOUT_W-1:0] end_col_ff, end_col_in;
   logic                empty_ff, empty_in;
   logic                lastrun_ff, lastrun_in;

   logic [IDX_W-1:0]    idx;
   logic                out_free, in_range, is_last, seen_c;
   logic [CIX_W-1:0]    c;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx      = IDX_W'(int'(row_ff) * GRID_CELLS + int'(emit_ff));
   assign in_range = int'(idx) < int'(glyph_count);
   assign is_last  = (int'(emit_ff) == GRID_CELLS - 1) || (int'(idx) + 1 >= int'(glyph_count));
   assign c        = pop_item.cell_pos[CIX_W-1:0];
   assign seen_c   = pop_item.clear ? 1'b0 : seen_ff[c];

   assign pop_ready = state_ff == BK_RUN;

   always_comb begin
      state_in     = state_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      seen_in      = seen_ff;
      emit_in      = emit_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cidx_in      = cidx_ff;
      first_col_in = first_col_ff;
      end_col_in   = end_col_ff;
      empty_in     = empty_ff;
      lastrun_in   = lastrun_ff;
      case (state_ff)
         BK_RUN: begin
            if (pop_valid) begin
               if (pop_item.clear) seen_in = '0;
               if (pop_item.ink) begin
                  if (!seen_c || pop_item.x < first_ff[c]) first_in[c] = pop_item.x;
                  if (!seen_c || pop_item.x > last_ff[c]) last_in[c] = pop_item.x;
                  seen_in[c] = 1'b1;
               end
               if (pop_item.flush) begin
                  row_in   = pop_item.row;
                  emit_in  = '0;
                  state_in = BK_EMIT;
               end
            end
         end
         BK_EMIT: begin
            if (!in_range) begin
               seen_in  = '0;
               state_in = BK_RUN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               cidx_in      = CIDX_W'(idx);
               empty_in     = !seen_ff[emit_ff];
               first_col_in = seen_ff[emit_ff] ? COLOUT_W'(first_ff[emit_ff]) : '0;
               end_col_in   = seen_ff[emit_ff] ?
                              COLOUT_W'({1'b0, last_ff[emit_ff]} + CW_W'(1)) : '0;
               lastrun_in   = is_last;
               if (is_last) begin
                  seen_in  = '0;
                  state_in = BK_RUN;
               end else begin
                  emit_in = emit_ff + CIX_W'(1);
               end
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_RUN;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff     <= first_in;
      last_ff      <= last_in;
      emit_ff      <= emit_in;
      row_ff       <= row_in;
      cidx_ff      <= cidx_in;
      first_col_ff <= first_col_in;
      end_col_ff   <= end_col_in;
      empty_ff     <= empty_in;
      lastrun_ff   <= lastrun_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_index   = cidx_ff;
   assign rsp_first_column = first_col_ff;
   assign rsp_end_column   = end_col_ff;
   assign rsp_empty_cell   = empty_ff;
   assign rsp_last_of_run  = lastrun_ff;

   a_empty_zero_columns: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && empty_ff) |-> (first_col_ff == '0 && end_col_ff == '0))
      else $error("empty cell reported with nonzero columns");

endmodule
